// ----- hw/rtl/hsa_pkg.sv -----
// ----------------------------------------------------------------------------
// hsa_pkg
// shared types and constants for the hsl saturation adjust block
// ----------------------------------------------------------------------------
package hsa_pkg;

    localparam int CH_W     = 8;    // bits per color channel
    localparam int NUM_CH   = 3;    // red, green, blue
    localparam int SUM_W    = 9;    // max + min
    localparam int PCT_MAX  = 100;  // full scale of the percentage
    localparam int HALF_SUM = 255;  // max + min below this is a dark pixel
    localparam int FULL_SUM = 510;  // largest possible max + min

    // pixel data that rides alongside the gain divider
    typedef struct packed {
        logic [NUM_CH-1:0][CH_W-1:0] rgb;   // index 0 red, 1 green, 2 blue
        logic [SUM_W-1:0]            sum;   // max + min
        logic                        gray;  // max equals min
        logic                        neg;   // desaturating setting
    } t_side;

endpackage

// ----- hw/rtl/hsa_div.sv -----
// ----------------------------------------------------------------------------
// hsa_div
// pipelined restoring divider, one quotient bit per stage: (num << F) / den
// ----------------------------------------------------------------------------
module hsa_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_ce,
    input  logic                   i_vld,
    input  logic [7:0]             i_num,
    input  logic [7:0]             i_den,
    input  hsa_pkg::t_side         i_side,
    output logic                   o_vld,
    output logic [FRAC_BITS+7:0]   o_quo,
    output hsa_pkg::t_side         o_side
);
    import hsa_pkg::*;

    localparam int QW = FRAC_BITS + CH_W;

    logic          r_vld  [0:QW-1];
    logic [7:0]    r_rem  [0:QW-1];
    logic [7:0]    r_num  [0:QW-1];
    logic [7:0]    r_den  [0:QW-1];
    logic [QW-1:0] r_quo  [0:QW-1];
    t_side         r_side [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          s_vld;
        logic [7:0]    s_rem;
        logic [7:0]    s_num;
        logic [7:0]    s_den;
        logic [QW-1:0] s_quo;
        t_side         s_side;
        logic          s_bit;
        logic [9:0]    s_diff;
        logic          s_qb;
        logic [7:0]    n_rem;
        logic [QW-1:0] n_quo;

        if (k == 0) begin : g_first
            assign s_vld  = i_vld;
            assign s_rem  = '0;
            assign s_num  = i_num;
            assign s_den  = i_den;
            assign s_quo  = '0;
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_num  = r_num[k-1];
            assign s_den  = r_den[k-1];
            assign s_quo  = r_quo[k-1];
            assign s_side = r_side[k-1];
        end

        // dividend bits: numerator first, then the fractional zeros
        if (k < CH_W) begin : g_numbit
            assign s_bit = s_num[CH_W-1-k];
        end else begin : g_zerobit
            assign s_bit = 1'b0;
        end

        always_comb begin
            s_diff = {1'b0, s_rem, s_bit} - {2'b00, s_den};
            s_qb   = ~s_diff[9];
            n_rem  = s_qb ? s_diff[7:0] : {s_rem[6:0], s_bit};
            n_quo  = {s_quo[QW-2:0], s_qb};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ce) begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k]  <= n_rem;
                r_num[k]  <= s_num;
                r_den[k]  <= s_den;
                r_quo[k]  <= n_quo;
                r_side[k] <= s_side;
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quo  = r_quo[QW-1];
    assign o_side = r_side[QW-1];

endmodule

// ----- hw/rtl/hsl_saturation_adjust.sv -----
// ----------------------------------------------------------------------------
// hsl_saturation_adjust
// changes the hsl saturation of an rgb pixel stream by a signed percentage
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                      content
//  s_axis    in   s_axis_tvalid / s_axis_tready  pixel: red, green, blue
//  m_axis    out  m_axis_tvalid / m_axis_tready  adjusted red, green, blue
//  sat cfg   in   i_sat_wr_en                    saturation percent, -100..100
//
//  one pixel beat per cycle while m_axis is not stalled; the pipeline runs
//  through stages 1 to 3, the gain divider, the multiply stage and the output
//  stage, and the divider retires one quotient bit per stage over FRAC_BITS + 8 stages
//  reset is synchronous, active low; it clears the valid bits and sets the
//  percentage to zero
//  a stall on m_axis freezes every stage at once; s_axis_tready is high
//  whenever the output register is empty or being taken
//
module hsl_saturation_adjust #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_sat_wr_en,
    input  logic [7:0]  i_sat_wr_data,   // signed percent
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // in_red, in_green, in_blue
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata     // out_red, out_green, out_blue
);
    import hsa_pkg::*;

    localparam int QW  = FRAC_BITS + CH_W;   // gain width
    localparam int PW  = FRAC_BITS + 20;     // product / accumulator width
    localparam int VW  = PW - FRAC_BITS - 1; // integer part after shift
    localparam int PRW = 15;                 // threshold product width

    // global stage enable: everything advances together
    logic w_ce;
    assign w_ce          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_ce;

    // ---------------- configuration register, clamped on write
    logic signed [7:0] r_pct;
    logic signed [7:0] n_pct;

    always_comb begin
        n_pct = $signed(i_sat_wr_data);
        if ($signed(i_sat_wr_data) > $signed(8'(PCT_MAX))) begin
            n_pct = 8'(PCT_MAX);
        end else if ($signed(i_sat_wr_data) < -$signed(8'(PCT_MAX))) begin
            n_pct = -$signed(8'(PCT_MAX));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct <= '0;
        end else if (i_sat_wr_en) begin
            r_pct <= n_pct;
        end
    end

    // ---------------- stage 1: max, min, sum, spread
    logic            r_s1_vld;
    t_side           r_s1_sd;
    logic [7:0]      r_s1_spread;
    t_side           n_s1_sd;
    logic [7:0]      n_s1_spread;
    logic [7:0]      w_mx;
    logic [7:0]      w_mn;

    always_comb begin
        n_s1_sd.rgb[0] = s_axis_tdata[7:0];
        n_s1_sd.rgb[1] = s_axis_tdata[15:8];
        n_s1_sd.rgb[2] = s_axis_tdata[23:16];
        w_mx = n_s1_sd.rgb[0];
        w_mn = n_s1_sd.rgb[0];
        for (int i = 1; i < NUM_CH; i++) begin
            if (n_s1_sd.rgb[i] > w_mx) begin
                w_mx = n_s1_sd.rgb[i];
            end
            if (n_s1_sd.rgb[i] < w_mn) begin
                w_mn = n_s1_sd.rgb[i];
            end
        end
        n_s1_sd.sum  = {1'b0, w_mx} + {1'b0, w_mn};
        n_s1_sd.gray = (w_mx == w_mn);
        n_s1_sd.neg  = r_pct[7];
        n_s1_spread  = w_mx - w_mn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_ce) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_s1_sd     <= n_s1_sd;
            r_s1_spread <= n_s1_spread;
        end
    end

    // ---------------- stage 2: denominator of s and the threshold products
    logic            r_s2_vld;
    t_side           r_s2_sd;
    logic [7:0]      r_s2_spread;
    logic [7:0]      r_s2_den;
    logic [PRW-1:0]  r_s2_pden;
    logic [PRW-1:0]  r_s2_hspr;
    logic [PRW-1:0]  r_s2_hden;
    logic [7:0]      n_s2_den;
    logic [SUM_W-1:0] w_light_den;

    always_comb begin
        w_light_den = SUM_W'(FULL_SUM) - r_s1_sd.sum;
        // light pixels measure spread against 510 - max - min
        if (r_s1_sd.sum < SUM_W'(HALF_SUM)) begin
            n_s2_den = r_s1_sd.sum[7:0];
        end else begin
            n_s2_den = w_light_den[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_ce) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_s2_sd     <= r_s1_sd;
            r_s2_spread <= r_s1_spread;
            r_s2_den    <= n_s2_den;
            r_s2_pden   <= PRW'(r_pct[6:0]) * PRW'(n_s2_den);
            r_s2_hspr   <= PRW'(r_s1_spread) * PRW'(PCT_MAX);
            r_s2_hden   <= PRW'(n_s2_den) * PRW'(PCT_MAX);
        end
    end

    // ---------------- stage 3: pick the gain fraction num / den
    logic            r_s3_vld;
    t_side           r_s3_sd;
    logic [7:0]      r_s3_num;
    logic [7:0]      r_s3_den;
    logic [7:0]      n_s3_num;
    logic [7:0]      n_s3_den;
    logic            w_full;

    always_comb begin
        // p/100 + s >= 1, decided on integers
        w_full = ({1'b0, r_s2_pden} + {1'b0, r_s2_hspr}) >= {1'b0, r_s2_hden};
        if (r_s2_sd.neg) begin
            // scale toward lightness by (100 + p) / 100
            n_s3_num = r_pct + 8'(PCT_MAX);
            n_s3_den = 8'(PCT_MAX);
        end else if (w_full) begin
            // gain 1/s - 1
            n_s3_num = r_s2_den - r_s2_spread;
            n_s3_den = r_s2_spread;
        end else begin
            n_s3_num = r_pct;
            n_s3_den = 8'(PCT_MAX) - r_pct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_ce) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_s3_sd  <= r_s2_sd;
            r_s3_num <= n_s3_num;
            r_s3_den <= n_s3_den;
        end
    end

    // ---------------- gain divider, QW stages
    logic            w_div_vld;
    logic [QW-1:0]   w_gain;
    t_side           w_div_sd;

    hsa_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_vld   (r_s3_vld),
        .i_num   (r_s3_num),
        .i_den   (r_s3_den),
        .i_side  (r_s3_sd),
        .o_vld   (w_div_vld),
        .o_quo   (w_gain),
        .o_side  (w_div_sd)
    );

    // ---------------- multiply stage: (2c - sum) * gain and the base term
    logic                  r_m_vld;
    t_side                 r_m_sd;
    logic signed [PW-1:0]  r_m_prod [0:NUM_CH-1];
    logic signed [PW-1:0]  r_m_base [0:NUM_CH-1];
    logic signed [PW-1:0]  n_m_prod [0:NUM_CH-1];
    logic signed [PW-1:0]  n_m_base [0:NUM_CH-1];
    logic signed [10:0]    w_d2     [0:NUM_CH-1];

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            w_d2[i] = {2'b00, w_div_sd.rgb[i], 1'b0} - {2'b00, w_div_sd.sum};
            n_m_prod[i] = w_d2[i] * $signed({1'b0, w_gain});
            // halves of lightness kept exact: everything scaled by 2^(F+1)
            if (w_div_sd.neg) begin
                n_m_base[i] = PW'({w_div_sd.sum, {FRAC_BITS{1'b0}}});
            end else begin
                n_m_base[i] = PW'({w_div_sd.rgb[i], {(FRAC_BITS+1){1'b0}}});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_ce) begin
            r_m_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_m_sd <= w_div_sd;
            for (int i = 0; i < NUM_CH; i++) begin
                r_m_prod[i] <= n_m_prod[i];
                r_m_base[i] <= n_m_base[i];
            end
        end
    end

    // ---------------- output stage: add, truncate, clamp; gray pixels pass through
    logic                 r_out_vld;
    logic [23:0]          r_out_data;
    logic [23:0]          n_out_data;
    logic signed [PW-1:0] w_acc [0:NUM_CH-1];
    logic [VW-1:0]        w_int [0:NUM_CH-1];
    logic [7:0]           w_ch  [0:NUM_CH-1];

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            w_acc[i] = r_m_prod[i] + r_m_base[i];
            w_int[i] = w_acc[i][PW-1:FRAC_BITS+1];
            if (r_m_sd.gray) begin
                w_ch[i] = r_m_sd.rgb[i];
            end else if (w_acc[i][PW-1]) begin
                w_ch[i] = '0;
            end else if (|w_int[i][VW-1:CH_W]) begin
                w_ch[i] = '1;
            end else begin
                w_ch[i] = w_int[i][CH_W-1:0];
            end
        end
        n_out_data = {w_ch[2], w_ch[1], w_ch[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ce) begin
            r_out_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule
